FILE: hdl/krsm_pkg.sv
// Shared types and constants for the record substring matcher.
// No dependencies; imported by krsm_ctrl, krsm_dp and the top level.
package krsm_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int IDX_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 4;
  localparam int CHAR_W      = 8;
  localparam int CNT_W       = 16;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 1;
  localparam int OUT_DATA_W  = 24;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_BUILD,
    ST_IDLE,
    ST_MATCH
  } ctrl_state_t;

  typedef struct packed {
    logic build_start;
    logic build_step;
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic build_done;
    logic match_ready;
    logic out_free;
  } dp_status_t;

  // Length register as used: zero acts as one, large values clip to the max.
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (raw > LEN_W'(MAX_PATTERN)) begin
      len = LEN_W'(MAX_PATTERN);
    end
    return len;
  endfunction

  function automatic logic [CHAR_W-1:0] pat_byte(input logic [CFG_DATA_W-1:0] chars,
                                                 input logic [IDX_W-1:0] idx);
    return chars[CHAR_W*idx +: CHAR_W];
  endfunction

endpackage

FILE: hdl/kmp_record_substring_matcher_core.sv
// Top level of the record substring matcher: stream ports, pattern write port,
// controller and datapath. Uses krsm_pkg, krsm_ctrl and krsm_dp.
//
// Matches a byte stream, split into records, against a pattern of 1 to 8 bytes
// by Knuth-Morris-Pratt and returns one result per character. After a character
// is taken, the matcher walks the prefix table one entry per cycle for each
// fallback it needs (at most pattern length - 1), then commits the result once
// the output register is free; one character is in work at a time. The output
// register lets the next character be taken while a result waits. A write to
// either pattern register in the build or idle state rebuilds the prefix table,
// one step per cycle; s_tready stays low until it finishes, also right after
// reset.
module kmp_record_substring_matcher_core import krsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [CHAR_W-1:0]     s_tdata,   // [7:0] text_char
  input  logic                  s_tlast,   // end_of_record
  input  logic                  s_tuser,   // [0] last_of_list
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // [0] match_end, [1] record_match,
                                           // [17:2] record_number, [23:18] zero
  output logic                  m_tlast,   // record_done
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic             match_end;
  logic             record_match;
  logic [CNT_W-1:0] record_number;

  krsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cfg_we   (cfg_we),
    .status   (status),
    .cmd      (cmd)
  );

  krsm_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_data          (cfg_data),
    .in_char           (s_tdata),
    .in_eor            (s_tlast),
    .in_last           (s_tuser),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .out_match_end     (match_end),
    .out_record_match  (record_match),
    .out_record_number (record_number),
    .out_record_done   (m_tlast)
  );

  assign m_tdata = {(OUT_DATA_W - CNT_W - 2)'(0), record_number, record_match, match_end};

endmodule

FILE: hdl/krsm_ctrl.sv
// Controller for the record substring matcher: prefix-table build sequencing,
// character acceptance, fallback iteration and result hand-off. Uses krsm_pkg.
module krsm_ctrl import krsm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic       cfg_we,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BUILD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_BUILD: begin
        if (cfg_we) begin
          cmd.build_start = 1'b1;
        end else if (status.build_done) begin
          state_next = ST_IDLE;
        end else begin
          cmd.build_step = 1'b1;
        end
      end
      ST_IDLE: begin
        if (cfg_we) begin
          cmd.build_start = 1'b1;
          state_next      = ST_BUILD;
        end else begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.load   = 1'b1;
            state_next = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        if (!status.match_ready) begin
          cmd.step = 1'b1;
        end else if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_BUILD;
      end
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> status.out_free)
    else $error("result committed into a full output slot");

endmodule

FILE: hdl/krsm_dp.sv
// Datapath for the record substring matcher: pattern registers, prefix table,
// match length, record tracking and the output register. Uses krsm_pkg.
module krsm_dp import krsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CHAR_W-1:0]     in_char,
  input  logic                  in_eor,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_match_end,
  output logic                  out_record_match,
  output logic [CNT_W-1:0]      out_record_number,
  output logic                  out_record_done
);

  logic [CFG_DATA_W-1:0] pat_chars;
  logic [LEN_W-1:0]      pat_len;
  logic [IDX_W-1:0]      pi [MAX_PATTERN];
  logic [IDX_W-1:0]      pi_last;
  logic [LEN_W-1:0]      bi;
  logic [IDX_W-1:0]      bk;
  logic [LEN_W-1:0]      mlen;
  logic [CHAR_W-1:0]     char_r;
  logic                  eor_r;
  logic                  last_r;
  logic                  record_hit;
  logic [CNT_W-1:0]      record_counter;

  logic [LEN_W-1:0]  len_eff;
  logic              build_done;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  pi_rd;
  logic [CHAR_W-1:0] pat_i, pat_k, pat_m;
  logic              k_fall, m_fall;
  logic [IDX_W-1:0]  k_inc;
  logic [LEN_W-1:0]  m_adv, m_new;
  logic              hit, done, hit_rec;

  always_comb begin
    len_eff    = eff_len(pat_len);
    build_done = bi >= len_eff;
    // table is read by the builder or by the matcher, never both at once
    rd_addr = build_done ? (mlen[IDX_W-1:0] - IDX_W'(1)) : (bk - IDX_W'(1));
    pi_rd   = pi[rd_addr];

    pat_i  = pat_byte(pat_chars, bi[IDX_W-1:0]);
    pat_k  = pat_byte(pat_chars, bk);
    k_fall = (bk != '0) && (pat_i != pat_k);
    k_inc  = bk + IDX_W'(pat_i == pat_k);

    pat_m   = pat_byte(pat_chars, mlen[IDX_W-1:0]);
    m_fall  = (mlen != '0) && (pat_m != char_r);
    m_adv   = mlen + LEN_W'(pat_m == char_r);
    hit     = m_adv >= len_eff;
    m_new   = hit ? LEN_W'(pi_last) : m_adv;
    done    = eor_r | last_r;
    hit_rec = record_hit | hit;

    status.build_done  = build_done;
    status.match_ready = !m_fall;
    status.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_chars <= '0;
      pat_len   <= LEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_PATTERN_CHARS:  pat_chars <= cfg_data;
        REG_PATTERN_LENGTH: pat_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // prefix table build, one fallback or one entry per cycle
  always_ff @(posedge clk) begin
    if (rst || cmd.build_start) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        pi[j] <= '0;
      end
      pi_last <= '0;
      bi      <= LEN_W'(1);
      bk      <= '0;
    end else if (cmd.build_step) begin
      if (k_fall) begin
        bk <= pi_rd;
      end else begin
        bk                 <= k_inc;
        pi[bi[IDX_W-1:0]]  <= k_inc;
        if (bi == len_eff - LEN_W'(1)) begin
          pi_last <= k_inc;
        end
        bi <= bi + LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_r <= in_char;
      eor_r  <= in_eor;
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mlen           <= '0;
      record_hit     <= 1'b0;
      record_counter <= '0;
    end else if (cmd.build_start) begin
      mlen <= '0;
    end else if (cmd.load) begin
      if (mlen >= len_eff) begin
        mlen <= '0;
      end
    end else if (cmd.step) begin
      mlen <= LEN_W'(pi_rd);
    end else if (cmd.commit) begin
      mlen       <= done ? '0 : m_new;
      record_hit <= done ? 1'b0 : hit_rec;
      if (last_r) begin
        record_counter <= '0;
      end else if (eor_r && record_counter != '1) begin
        record_counter <= record_counter + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_match_end     <= hit;
      out_record_match  <= done & hit_rec;
      out_record_number <= record_counter;
      out_record_done   <= done;
    end
  end

  a_mlen_bound: assert property (@(posedge clk) disable iff (rst) mlen < len_eff)
    else $error("match length reached pattern length");
  a_build_order: assert property (@(posedge clk) disable iff (rst)
    LEN_W'(bk) < bi)
    else $error("prefix build index out of order");
  a_list_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && last_r |=> record_counter == '0)
    else $error("record counter not cleared at end of list");

endmodule

FILE: dv/kmp_record_substring_matcher_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for kmp_record_substring_matcher_core: streams records through the
// matcher with random gaps and stalls and checks every result against an in-bench KMP model.
// Depends on krsm_pkg and the matcher RTL.
module kmp_record_substring_matcher_core_test;
  import krsm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 2 * MAX_PATTERN + 4;
  localparam int MAX_PRINTED  = 40;
  localparam int COUNT_TOP    = 65535;
  localparam int NUM_LSB      = 2;
  localparam logic [CHAR_W-1:0] CH_A = 8'h41;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              eor;
    logic              lol;
  } text_item_t;

  typedef struct packed {
    logic             match_end;
    logic             record_match;
    logic [CNT_W-1:0] record_number;
    logic             record_done;
  } match_result_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [CHAR_W-1:0]     s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_PATTERN_CHARS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire                   m_tlast;
  wire  [OUT_DATA_W-1:0] m_tdata;

  kmp_record_substring_matcher_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // Matcher model state
  logic [CFG_DATA_W-1:0] pat_reg   = '0;
  logic [LEN_W-1:0]      len_reg   = LEN_W'(1);
  int unsigned           border[MAX_PATTERN];
  int unsigned           span_now  = 0;
  logic                  rec_hit   = 1'b0;
  int unsigned           rec_count = 0;

  text_item_t    pending_q[$];
  match_result_t expect_q[$];

  int unsigned items_queued = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt      = 0;
  int unsigned n_writes     = 0;
  int unsigned n_records    = 0;
  int unsigned n_matches    = 0;
  int unsigned cycle_cnt    = 0;
  int          gap_pct      = 0;
  int          stall_pct    = 0;
  int          gap_left     = 0;
  int          stall_left   = 0;
  int          hold_left    = 0;
  bit          held_once    = 1'b0;
  logic        in_taken     = 1'b0;

  function automatic int unsigned active_len();
    int unsigned n;
    n = len_reg;
    if (n < 1) n = 1;
    if (n > MAX_PATTERN) n = MAX_PATTERN;
    return n;
  endfunction

  function automatic logic [CHAR_W-1:0] pat_at(input int unsigned idx);
    return pat_reg[CHAR_W*idx +: CHAR_W];
  endfunction

  function automatic void rebuild_border();
    int unsigned k;
    int unsigned len;
    len = active_len();
    k = 0;
    foreach (border[i]) border[i] = 0;
    for (int unsigned i = 1; i < len; i++) begin
      while (k > 0 && pat_at(i) != pat_at(k)) k = border[k-1];
      if (pat_at(i) == pat_at(k)) k++;
      border[i] = k;
    end
    span_now = 0;
  endfunction

  task automatic kmp_advance(input text_item_t it, output match_result_t r);
    int unsigned len;
    int unsigned q;
    logic full;
    logic done;
    len = active_len();
    q = span_now;
    full = 1'b0;
    if (q >= len) q = 0;
    while (q > 0 && pat_at(q) != it.ch) q = border[q-1];
    if (pat_at(q) == it.ch) q++;
    if (q >= len) begin
      full = 1'b1;
      q = border[len-1];
      n_matches++;
    end
    span_now = q;
    if (full) rec_hit = 1'b1;
    done = it.eor | it.lol;
    r.match_end     = full;
    r.record_match  = done & rec_hit;
    r.record_number = rec_count[CNT_W-1:0];
    r.record_done   = done;
    if (done) begin
      n_records++;
      span_now = 0;
      rec_hit = 1'b0;
      if (it.lol) rec_count = 0;
      else if (rec_count < COUNT_TOP) rec_count++;
    end
  endtask

  task automatic flag_error(input string what);
    if (err_cnt < MAX_PRINTED) $display("ERROR @%0t: %s", $time, what);
    err_cnt++;
  endtask

  // Transfer into the matcher: model runs at acceptance. Result transfer: compare.
  always @(posedge clk) begin
    text_item_t    got_in;
    match_result_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        got_in = {s_tdata, s_tlast, s_tuser};
        kmp_advance(got_in, want);
        expect_q.insert(expect_q.size(), want);
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expect_q.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected: data %h last %b",
                               results_seen, m_tdata, m_tlast));
        end else begin
          want = expect_q.pop_front();
          if (m_tdata[0] !== want.match_end)
            flag_error($sformatf("result %0d match_end %b, want %b",
                                 results_seen, m_tdata[0], want.match_end));
          if (m_tdata[1] !== want.record_match)
            flag_error($sformatf("result %0d record_match %b, want %b",
                                 results_seen, m_tdata[1], want.record_match));
          if (m_tdata[NUM_LSB +: CNT_W] !== want.record_number)
            flag_error($sformatf("result %0d record_number %0d, want %0d",
                                 results_seen, m_tdata[NUM_LSB +: CNT_W], want.record_number));
          if (m_tdata[OUT_DATA_W-1:NUM_LSB+CNT_W] !== '0)
            flag_error($sformatf("result %0d padding bits %b not zero",
                                 results_seen, m_tdata[OUT_DATA_W-1:NUM_LSB+CNT_W]));
          if (m_tlast !== want.record_done)
            flag_error($sformatf("result %0d record_done %b, want %b",
                                 results_seen, m_tlast, want.record_done));
        end
      end
    end
  end

  // Character driver
  always @(negedge clk) begin
    logic       offer;
    text_item_t nxt;
    offer = s_tvalid;
    if (!rst && (!s_tvalid || in_taken)) begin
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
          gap_left = $urandom_range(15, 0);
        end else begin
          nxt = pending_q.pop_front();
          offer = 1'b1;
          s_tdata <= nxt.ch;
          s_tlast <= nxt.eor;
          s_tuser <= nxt.lol;
        end
      end
    end
    s_tvalid <= offer;
  end

  // Result receiver; one long hold-off early on backs the matcher up to its input
  always @(negedge clk) begin
    logic take;
    take = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      take = 1'b0;
    end else if (!held_once && results_seen >= 150 && pending_q.size() > 40) begin
      held_once = 1'b1;
      hold_left = 299;
      take = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      take = 1'b0;
    end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
      stall_left = $urandom_range(15, 0);
      take = 1'b0;
    end
    m_tready <= take;
  end

  task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= which;
    cfg_data <= val;
    @(posedge clk);
    if (which == REG_PATTERN_CHARS) pat_reg = val;
    else len_reg = val[LEN_W-1:0];
    rebuild_border();
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_char(input logic [CHAR_W-1:0] c, input logic eor, input logic lol);
    pending_q.insert(pending_q.size(), {c, eor, lol});
    items_queued++;
  endtask

  function automatic int pick_rate();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 8;
      default: return 25;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] make_pattern();
    logic [CFG_DATA_W-1:0] w;
    int style;
    style = $urandom_range(3);
    w = {$urandom, $urandom};
    for (int b = 0; b < MAX_PATTERN; b++) begin
      case (style)
        1: w[CHAR_W*b +: CHAR_W] = CH_A + CHAR_W'($urandom_range(1));
        2: w[CHAR_W*b +: CHAR_W] = CH_A + CHAR_W'($urandom_range(2));
        3: w[CHAR_W*b +: CHAR_W] = CH_A;
        default: ;
      endcase
    end
    if (style == 3) w[CHAR_W*$urandom_range(MAX_PATTERN-1) +: CHAR_W] = CH_A + CHAR_W'(1);
    return w;
  endfunction

  // Upper length bits are don't-care; keep them random
  task automatic set_pattern(input logic [CFG_DATA_W-1:0] chars, input logic [LEN_W-1:0] len_code,
                             input bit may_skip);
    logic [CFG_DATA_W-1:0] lw;
    lw = {$urandom, $urandom};
    lw[LEN_W-1:0] = len_code;
    case (may_skip ? $urandom_range(5) : $urandom_range(1))
      0, 2:    begin write_reg(REG_PATTERN_CHARS, chars); write_reg(REG_PATTERN_LENGTH, lw); end
      1, 3:    begin write_reg(REG_PATTERN_LENGTH, lw); write_reg(REG_PATTERN_CHARS, chars); end
      4:       write_reg(REG_PATTERN_CHARS, chars);
      default: write_reg(REG_PATTERN_LENGTH, lw);
    endcase
  endtask

  // Records built mostly from pattern copies, prefixes and pattern bytes, with some noise.
  // The run may stop mid-record, so the next pattern write lands inside a record.
  task automatic gen_text(input int unsigned n);
    int unsigned len;
    int unsigned rec_left;
    int unsigned copy_pos;
    int unsigned copy_end;
    logic [CHAR_W-1:0] c;
    logic eor;
    logic lol;
    len = active_len();
    rec_left = $urandom_range(12, 1);
    copy_pos = 0;
    copy_end = 0;
    repeat (n) begin
      if (copy_pos < copy_end) begin
        c = pat_at(copy_pos);
        copy_pos++;
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            copy_end = $urandom_range(1) ? len : $urandom_range(len, 1);
            c = pat_at(0);
            copy_pos = 1;
          end
          4, 5, 6: c = pat_at($urandom_range(len - 1));
          default: c = CHAR_W'($urandom_range(255));
        endcase
      end
      eor = 1'b0;
      lol = 1'b0;
      rec_left--;
      if (rec_left == 0) begin
        eor = 1'b1;
        if ($urandom_range(7) == 0) begin
          lol = 1'b1;
          eor = 1'($urandom_range(1));
        end
        rec_left = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(12, 1);
        copy_end = 0;
      end
      push_char(c, eor, lol);
    end
  endtask

  initial begin
    int extremes[4];
    extremes = '{MAX_PATTERN, 1, 0, 15};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a single zero byte
    push_char(8'h00, 1'b0, 1'b0);
    push_char(8'hFF, 1'b1, 1'b0);
    push_char(8'h55, 1'b0, 1'b1);
    settle();

    // Overlapping "ABA"; a record left open across the next pattern write
    write_reg(REG_PATTERN_CHARS, 64'hFFFF_FFFF_FF41_4241);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    push_char("A", 1'b0, 1'b0); push_char("B", 1'b0, 1'b0); push_char("A", 1'b0, 1'b0);
    push_char("B", 1'b0, 1'b0); push_char("A", 1'b1, 1'b0);
    push_char("A", 1'b0, 1'b0); push_char("B", 1'b0, 1'b0); push_char("X", 1'b1, 1'b0);
    push_char("A", 1'b1, 1'b1);
    push_char("A", 1'b0, 1'b0); push_char("B", 1'b0, 1'b0); push_char("A", 1'b0, 1'b0);
    settle();

    // Zero length acts as one; record hit survives the write
    write_reg(REG_PATTERN_CHARS, 64'h0000_0000_0000_005A);
    write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    push_char("Y", 1'b1, 1'b0);
    push_char("Z", 1'b0, 1'b0);
    push_char("Z", 1'b1, 1'b1);
    settle();

    // Oversized length clips to eight, all-ones pattern
    write_reg(REG_PATTERN_CHARS, '1);
    write_reg(REG_PATTERN_LENGTH, 64'd15);
    repeat (8) push_char(8'hFF, 1'b0, 1'b0);
    push_char(8'hFF, 1'b1, 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle();
      gap_pct   = pick_rate();
      stall_pct = pick_rate();
      if (p < 4) set_pattern(make_pattern(), LEN_W'(extremes[p]), 1'b0);
      else if ($urandom_range(4) == 0) set_pattern(make_pattern(), LEN_W'($urandom_range(15)), 1'b1);
      else set_pattern(make_pattern(), LEN_W'($urandom_range(MAX_PATTERN, 1)), 1'b1);
      gen_text(p == 0 ? 300 : 120);
    end

    // Closing stretch with no idling on either side
    settle();
    gap_pct   = 0;
    stall_pct = 0;
    set_pattern(make_pattern(), LEN_W'($urandom_range(MAX_PATTERN, 1)), 1'b0);
    gen_text(120);
    settle();

    if (expect_q.size() != 0)
      flag_error($sformatf("%0d expected results never arrived", expect_q.size()));
    $display("Run covered %0d characters in %0d records, %0d full matches, %0d register writes",
             results_seen, n_records, n_matches, n_writes);
    $display("Patterns of length 1 to %0d, out-of-range lengths, list ends and a long stall",
             MAX_PATTERN);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/krsm_pkg.sv
hdl/krsm_ctrl.sv
hdl/krsm_dp.sv
hdl/kmp_record_substring_matcher_core.sv
dv/kmp_record_substring_matcher_core_test.sv
